@@ src/pstt_pkg.sv @@
// ----------------------------------------------------------------------------
// pstt_pkg
// Shared types and constants of the periodic sample timestamp tagger.
// ----------------------------------------------------------------------------
package pstt_pkg;

  localparam int unsigned SampleWidth   = 16;
  localparam int unsigned SecWidth      = 32;
  localparam int unsigned FracWidth     = 48;
  localparam int unsigned TimeWidth     = SecWidth + FracWidth;
  localparam int unsigned IdxWidth      = 48;
  localparam int unsigned IntervalWidth = 32;
  localparam int unsigned PeriodWidth   = 48;
  localparam int unsigned PeriodHalf    = PeriodWidth / 2;
  localparam int unsigned CfgDataWidth  = 48;
  localparam int unsigned CountWidthDef = 48;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [PeriodWidth-1:0] SamplePeriodRst = 48'd281474977;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_TAG_INTERVAL  = 1'b0;
  localparam cfg_idx_t CFG_SAMPLE_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    TAG_NONE     = 2'd0,
    TAG_REF      = 2'd1,
    TAG_PERIODIC = 2'd2
  } tag_kind_e;

  typedef struct packed {
    logic                    we;
    cfg_idx_t                idx;
    logic [CfgDataWidth-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [SampleWidth-1:0] sample_in;
    logic                   has_reference;
    logic [SecWidth-1:0]    ref_seconds;
    logic [FracWidth-1:0]   ref_fraction;
  } pstt_in_t;

  typedef struct packed {
    logic [SampleWidth-1:0] sample_out;
    tag_kind_e              tag_kind;
    logic [SecWidth-1:0]    tag_seconds;
    logic [FracWidth-1:0]   tag_fraction;
    logic [IdxWidth-1:0]    tag_sample_index;
  } pstt_out_t;

  typedef struct packed {
    logic [SampleWidth-1:0] sample;
    tag_kind_e              kind;
    logic [IdxWidth-1:0]    tag_sample_index;
    logic [SecWidth-1:0]    ref_seconds;
    logic [FracWidth-1:0]   ref_fraction;
  } q_item_t;

endpackage

@@ src/pstt_front.sv @@
// ----------------------------------------------------------------------------
// pstt_front
// Sample counter and tag scheduler: classifies each beat as untagged,
// reference echo or periodic tag and computes the samples elapsed.
// ----------------------------------------------------------------------------
module pstt_front import pstt_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_wr_t               cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pstt_in_t              in_data_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output q_item_t               q_item_o,
  output logic [CountWidth-1:0] q_elapsed_o
);

  logic [IntervalWidth-1:0] interval_q, interval_d;
  logic [CountWidth-1:0]    count_q, count_d;
  logic [CountWidth-1:0]    base_idx_q, base_idx_d;
  logic [CountWidth-1:0]    next_tag_q, next_tag_d;

  logic                     accept;
  logic                     is_ref;
  logic                     is_per;
  logic [CountWidth-1:0]    resched;
  logic [63:0]              idx_ext;
  logic [IntervalWidth-1:0] cfg_interval;
  tag_kind_e                kind;

  assign accept       = in_valid_i && q_ready_i;
  assign is_ref       = in_data_i.has_reference;
  assign is_per       = !is_ref && (interval_q != '0) && (next_tag_q == count_q);
  assign resched      = count_q + CountWidth'(interval_q);
  assign idx_ext      = 64'(count_q);
  assign cfg_interval = cfg_i.data[IntervalWidth-1:0];

  always_comb begin
    if (is_ref) begin
      kind = TAG_REF;
    end else if (is_per) begin
      kind = TAG_PERIODIC;
    end else begin
      kind = TAG_NONE;
    end
  end

  always_comb begin
    interval_d = interval_q;
    count_d    = count_q;
    base_idx_d = base_idx_q;
    next_tag_d = next_tag_q;
    if (cfg_i.we && cfg_i.idx == CFG_TAG_INTERVAL) begin
      interval_d = cfg_interval;
      if (cfg_interval != '0) begin
        next_tag_d = count_q + CountWidth'(cfg_interval);
      end
    end else if (accept) begin
      count_d = count_q + CountWidth'(1);
      if (is_ref || is_per) begin
        base_idx_d = count_q;
        next_tag_d = resched;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      count_q    <= '0;
      base_idx_q <= '0;
      next_tag_q <= '0;
    end else begin
      interval_q <= interval_d;
      count_q    <= count_d;
      base_idx_q <= base_idx_d;
      next_tag_q <= next_tag_d;
    end
  end

  assign in_ready_o                = q_ready_i;
  assign q_valid_o                 = in_valid_i;
  assign q_item_o.sample           = in_data_i.sample_in;
  assign q_item_o.kind             = kind;
  assign q_item_o.tag_sample_index = idx_ext[IdxWidth-1:0];
  assign q_item_o.ref_seconds      = in_data_i.ref_seconds;
  assign q_item_o.ref_fraction     = in_data_i.ref_fraction;
  assign q_elapsed_o               = count_q - base_idx_q;

endmodule

@@ src/pstt_queue.sv @@
// ----------------------------------------------------------------------------
// pstt_queue
// Short first-in first-out queue between the scheduler and the time unit.
// ----------------------------------------------------------------------------
module pstt_queue import pstt_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wptr_q, wptr_d;
  logic [PtrWidth-1:0] rptr_q, rptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                push;
  logic                pop;

  assign push_ready_o = (cnt_q != CntWidth'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrWidth'(Depth - 1)) ? '0 : wptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrWidth'(Depth - 1)) ? '0 : rptr_q + PtrWidth'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(Depth))
    else $error("queue fill count beyond depth");

endmodule

@@ src/pstt_back.sv @@
// ----------------------------------------------------------------------------
// pstt_back
// Time unit: elapsed x period in two stages, base time accumulator and
// output register.
// ----------------------------------------------------------------------------
module pstt_back import pstt_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_wr_t               cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  q_item_t               q_item_i,
  input  logic [CountWidth-1:0] q_elapsed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pstt_out_t             out_data_o
);

  localparam int unsigned LoW  = (CountWidth + 1) / 2;
  localparam int unsigned HiW  = CountWidth - LoW;
  localparam int unsigned PlW  = LoW + PeriodHalf;
  localparam int unsigned PhW  = HiW + PeriodHalf;

  logic [PeriodWidth-1:0] period_q;
  logic                   adv;

  logic [LoW-1:0]         e_lo;
  logic [HiW-1:0]         e_hi;
  logic [PeriodHalf-1:0]  p_lo;
  logic [PeriodHalf-1:0]  p_hi;

  logic                   s1_valid_q;
  q_item_t                s1_item_q;
  logic [PlW-1:0]         pp0_q, pp1_q;
  logic [PhW-1:0]         pp2_q, pp3_q;

  logic                   s2_valid_q;
  q_item_t                s2_item_q;
  logic [TimeWidth-1:0]   prod_q, prod_d;

  logic [TimeWidth-1:0]   base_q, base_d;
  logic                   out_valid_q;
  pstt_out_t              out_q, out_d;

  assign adv       = !out_valid_q || out_ready_i;
  assign q_ready_o = adv;

  assign e_lo = q_elapsed_i[LoW-1:0];
  assign e_hi = q_elapsed_i[CountWidth-1:LoW];
  assign p_lo = period_q[PeriodHalf-1:0];
  assign p_hi = period_q[PeriodWidth-1:PeriodHalf];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= SamplePeriodRst;
    end else if (cfg_i.we && cfg_i.idx == CFG_SAMPLE_PERIOD) begin
      period_q <= cfg_i.data[PeriodWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q <= q_item_i;
      pp0_q     <= PlW'(e_lo) * PlW'(p_lo);
      pp1_q     <= PlW'(e_lo) * PlW'(p_hi);
      pp2_q     <= PhW'(e_hi) * PhW'(p_lo);
      pp3_q     <= PhW'(e_hi) * PhW'(p_hi);
    end
  end

  assign prod_d = TimeWidth'(pp0_q)
                + (TimeWidth'(pp1_q) << PeriodHalf)
                + (TimeWidth'(pp2_q) << LoW)
                + (TimeWidth'(pp3_q) << (LoW + PeriodHalf));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_item_q <= s1_item_q;
      prod_q    <= prod_d;
    end
  end

  always_comb begin
    base_d = base_q;
    if (adv && s2_valid_q) begin
      case (s2_item_q.kind)
        TAG_REF:      base_d = {s2_item_q.ref_seconds, s2_item_q.ref_fraction};
        TAG_PERIODIC: base_d = base_q + prod_q;
        default:      base_d = base_q;
      endcase
    end
  end

  always_comb begin
    out_d.sample_out = s2_item_q.sample;
    out_d.tag_kind   = s2_item_q.kind;
    if (s2_item_q.kind != TAG_NONE) begin
      out_d.tag_seconds      = base_d[TimeWidth-1:FracWidth];
      out_d.tag_fraction     = base_d[FracWidth-1:0];
      out_d.tag_sample_index = s2_item_q.tag_sample_index;
    end else begin
      out_d.tag_seconds      = '0;
      out_d.tag_fraction     = '0;
      out_d.tag_sample_index = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      base_q <= base_d;
      if (adv) begin
        s1_valid_q  <= q_valid_i;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_untagged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tag_kind == TAG_NONE |->
      out_q.tag_seconds == '0 && out_q.tag_fraction == '0 &&
      out_q.tag_sample_index == '0)
    else $error("untagged beat carries tag fields");

  a_tag_is_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tag_kind != TAG_NONE |->
      {out_q.tag_seconds, out_q.tag_fraction} == base_q)
    else $error("tag time differs from base time");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s2_valid_q |=> out_valid_q)
    else $error("beat lost between last stage and output");

endmodule

@@ src/periodic_sample_timestamp_tagger.sv @@
// ----------------------------------------------------------------------------
// periodic_sample_timestamp_tagger
// Passes samples through and tags them with received or periodic timestamps.
// ----------------------------------------------------------------------------
// Sustains one sample per clock unless the output stalls; every accepted beat
// gives exactly one result beat via the queue, multiplier stages and output
// register. The scheduler tags a beat in its accept cycle; the time unit
// forms elapsed x period from four partial multipliers over two stages, and
// an 80-bit add of the base time closes the tag-to-tag loop. A four-entry
// queue between the two lets input and output stall on their own. No clearing
// pass after reset. Write configuration only while no beat is in flight.
// ----------------------------------------------------------------------------
module periodic_sample_timestamp_tagger import pstt_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  cfg_idx_t                cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pstt_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pstt_out_t               out_data_o
);

  localparam int unsigned QWidth = $bits(q_item_t) + CountWidth;

  cfg_wr_t               cfg;
  logic                  f_valid;
  logic                  f_ready;
  q_item_t               f_item;
  logic [CountWidth-1:0] f_elapsed;
  logic                  b_valid;
  logic                  b_ready;
  q_item_t               b_item;
  logic [CountWidth-1:0] b_elapsed;
  logic [QWidth-1:0]     push_data;
  logic [QWidth-1:0]     pop_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  pstt_front #(
    .CountWidth(CountWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .q_item_o   (f_item),
    .q_elapsed_o(f_elapsed)
  );

  assign push_data = {f_elapsed, f_item};

  pstt_queue #(
    .Width(QWidth),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (push_data),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (pop_data)
  );

  assign b_elapsed = pop_data[QWidth-1:$bits(q_item_t)];
  assign b_item    = q_item_t'(pop_data[$bits(q_item_t)-1:0]);

  pstt_back #(
    .CountWidth(CountWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (b_valid),
    .q_ready_o  (b_ready),
    .q_item_i   (b_item),
    .q_elapsed_i(b_elapsed),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ dv/tb_periodic_sample_timestamp_tagger.sv @@
// ----------------------------------------------------------------------------
// tb_periodic_sample_timestamp_tagger
// Self-checking testbench for the periodic sample timestamp tagger. A directed
// table covers reset, reference echo, the reference-wins case, interval zero,
// zero and extreme sample periods; random phases vary the register settings.
// Each output beat is checked in order against its table row or a predictor
// of tag schedule and base time, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_periodic_sample_timestamp_tagger;
  import pstt_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;
  localparam int NumPhases     = 16;

  typedef struct {
    bit                      is_cfg;
    cfg_idx_t                cfg_idx;
    logic [CfgDataWidth-1:0] cfg_data;
    pstt_in_t                beat;
    bit                      typed;
    pstt_out_t               tag;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  cfg_idx_t                cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  pstt_in_t                in_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  pstt_out_t               out_data_o;

  logic [IntervalWidth-1:0] cfg_interval = '0;
  logic [PeriodWidth-1:0]   cfg_period   = SamplePeriodRst;
  logic [IdxWidth-1:0]      smp_count    = '0;
  logic [SecWidth-1:0]      base_sec     = '0;
  logic [FracWidth-1:0]     base_frac    = '0;
  logic [IdxWidth-1:0]      base_idx     = '0;
  logic [IdxWidth-1:0]      next_tag     = '0;

  pstt_out_t exp_tags_q[$];
  dir_row_t  dir_rows[$];
  int        error_cnt    = 0;
  int        stall_cycles = 0;
  int        burst_left   = 0;
  bit        hold_req     = 1'b0;

  periodic_sample_timestamp_tagger DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic pstt_out_t predict_tag(input pstt_in_t b);
    pstt_out_t           r;
    logic [IdxWidth-1:0] idx;
    logic [IdxWidth-1:0] elapsed;
    logic [96:0]         acc;
    idx = smp_count;
    r = '0;
    r.sample_out = b.sample_in;
    r.tag_kind = TAG_NONE;
    if (b.has_reference) begin
      base_sec  = b.ref_seconds;
      base_frac = b.ref_fraction;
      base_idx  = idx;
      next_tag  = idx + IdxWidth'(cfg_interval);
      r.tag_kind = TAG_REF;
    end else if (cfg_interval != 0 && next_tag == idx) begin
      elapsed   = idx - base_idx;
      acc       = 97'(elapsed) * 97'(cfg_period) + 97'(base_frac);
      base_frac = acc[47:0];
      base_sec  = base_sec + acc[79:48];
      base_idx  = idx;
      next_tag  = idx + IdxWidth'(cfg_interval);
      r.tag_kind = TAG_PERIODIC;
    end
    if (r.tag_kind != TAG_NONE) begin
      r.tag_seconds      = base_sec;
      r.tag_fraction     = base_frac;
      r.tag_sample_index = idx;
    end
    smp_count = idx + 1'b1;
    return r;
  endfunction

  function automatic void add_beat(input logic [15:0] s, input bit r,
                                   input logic [31:0] sec, input logic [47:0] fr);
    dir_row_t row;
    row = '{default: '0};
    row.beat = '{sample_in: s, has_reference: r, ref_seconds: sec, ref_fraction: fr};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_tagged(input logic [15:0] s, input bit r,
                                     input logic [31:0] sec, input logic [47:0] fr,
                                     input tag_kind_e kind, input logic [31:0] esec,
                                     input logic [47:0] efr, input logic [47:0] eidx);
    dir_row_t row;
    row = '{default: '0};
    row.beat = '{sample_in: s, has_reference: r, ref_seconds: sec, ref_fraction: fr};
    row.typed = 1'b1;
    row.tag = '{sample_out: s, tag_kind: kind, tag_seconds: esec, tag_fraction: efr,
                tag_sample_index: eidx};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] data);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    dir_rows.push_back(row);
  endfunction

  function automatic pstt_in_t rand_beat(input int ref_pct);
    pstt_in_t b;
    b.sample_in     = 16'($urandom_range(0, 65535));
    b.has_reference = ($urandom_range(0, 99) < ref_pct);
    case ($urandom_range(0, 7))
      0:       b.ref_seconds = '0;
      1:       b.ref_seconds = '1;
      default: b.ref_seconds = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       b.ref_fraction = '0;
      1:       b.ref_fraction = '1;
      default: b.ref_fraction = 48'({$urandom, $urandom});
    endcase
    return b;
  endfunction

  task automatic send_beat(input pstt_in_t beat, input bit typed, input pstt_out_t tag);
    int        gap;
    pstt_out_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = predict_tag(beat);
    exp_tags_q.push_back(typed ? tag : pred);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (exp_tags_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TAG_INTERVAL) begin
      cfg_interval = data[IntervalWidth-1:0];
      if (cfg_interval != 0) next_tag = smp_count + IdxWidth'(cfg_interval);
    end else begin
      cfg_period = data[PeriodWidth-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
      error_cnt++;
    end
  endtask

  task automatic check_tag(input pstt_out_t exp, input pstt_out_t act);
    check_field("sample_out", 64'(exp.sample_out), 64'(act.sample_out));
    check_field("tag_kind", 64'(exp.tag_kind), 64'(act.tag_kind));
    check_field("tag_seconds", 64'(exp.tag_seconds), 64'(act.tag_seconds));
    check_field("tag_fraction", 64'(exp.tag_fraction), 64'(act.tag_fraction));
    check_field("tag_sample_index", 64'(exp.tag_sample_index), 64'(act.tag_sample_index));
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_tags_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %h", $time, out_data_o);
        error_cnt++;
      end else begin
        check_tag(exp_tags_q.pop_front(), out_data_o);
      end
    end
  end

  initial begin
    wait (stall_cycles >= WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    int                      n_items;
    int                      ref_pct;
    logic [IntervalWidth-1:0] ivl;
    logic [PeriodWidth-1:0]   per;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_TAG_INTERVAL;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    rst_ni      <= 1'b0;

    add_tagged(16'h0000, 1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, TAG_NONE, '0, '0, '0);
    add_tagged(16'hFFFF, 1'b0, 32'h0, 48'h0, TAG_NONE, '0, '0, '0);
    add_tagged(16'hA5A5, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               TAG_REF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd2);
    add_tagged(16'h5A5A, 1'b1, 32'h0, 48'h0, TAG_REF, 32'h0, 48'h0, 48'd3);
    add_tagged(16'h0001, 1'b0, 32'h5555_AAAA, 48'hAAAA_5555_AAAA, TAG_NONE, '0, '0, '0);
    add_cfg(CFG_TAG_INTERVAL, 48'hFFFF_0000_0003);
    add_beat(16'h1111, 1'b0, 32'hAAAA_5555, 48'h5555_AAAA_5555);
    add_beat(16'h2222, 1'b0, 32'h0, 48'h0);
    add_beat(16'h3333, 1'b0, 32'h0, 48'h0);
    add_beat(16'h4444, 1'b0, 32'h0, 48'h0);
    add_beat(16'h5555, 1'b0, 32'h0, 48'h0);
    add_beat(16'h6666, 1'b0, 32'h0, 48'h0);
    add_tagged(16'h7777, 1'b1, 32'h1234_5678, 48'h8000_0000_0000,
               TAG_REF, 32'h1234_5678, 48'h8000_0000_0000, 48'd11);
    add_beat(16'h8888, 1'b0, 32'h0, 48'h0);
    add_beat(16'h9999, 1'b0, 32'h0, 48'h0);
    add_beat(16'hAAAA, 1'b0, 32'h0, 48'h0);
    add_cfg(CFG_SAMPLE_PERIOD, 48'hFFFF_FFFF_FFFF);
    add_cfg(CFG_TAG_INTERVAL, 48'h0000_0000_0001);
    add_beat(16'hBBBB, 1'b0, 32'h0, 48'h0);
    add_beat(16'hCCCC, 1'b0, 32'h0, 48'h0);
    add_beat(16'hDDDD, 1'b0, 32'h0, 48'h0);
    add_cfg(CFG_SAMPLE_PERIOD, 48'h0);
    add_beat(16'hEEEE, 1'b0, 32'h0, 48'h0);
    add_beat(16'h0F0F, 1'b0, 32'h0, 48'h0);
    add_cfg(CFG_SAMPLE_PERIOD, 48'h1);
    add_beat(16'hF0F0, 1'b0, 32'h0, 48'h0);
    add_beat(16'h00FF, 1'b0, 32'h0, 48'h0);
    add_cfg(CFG_TAG_INTERVAL, 48'h0);
    add_tagged(16'hFF00, 1'b0, 32'h0, 48'h0, TAG_NONE, '0, '0, '0);
    add_tagged(16'h8001, 1'b1, 32'h8000_0001, 48'h0000_0000_0001,
               TAG_REF, 32'h8000_0001, 48'h0000_0000_0001, 48'd23);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        quiesce();
        cfg_write(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].tag);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case ($urandom_range(0, 5))
        0:       ivl = '0;
        1:       ivl = 32'd1;
        2:       ivl = $urandom_range(2, 8);
        3:       ivl = $urandom_range(9, 100);
        4:       ivl = '1;
        default: ivl = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       per = 48'd1;
        1:       per = '1;
        2:       per = '0;
        3:       per = SamplePeriodRst;
        default: per = 48'({$urandom, $urandom});
      endcase
      if (ph == 0) begin
        ivl = '1;
        per = '1;
      end else if (ph == 1) begin
        ivl = 32'd1;
        per = '0;
      end else if (ph == 2) begin
        ivl = 32'd2;
      end
      case ($urandom_range(0, 3))
        0:       ref_pct = 0;
        1:       ref_pct = 2;
        2:       ref_pct = 10;
        default: ref_pct = 50;
      endcase
      quiesce();
      cfg_write(CFG_TAG_INTERVAL, {16'($urandom_range(0, 65535)), ivl});
      if (ph < 3 || $urandom_range(0, 3) != 0) cfg_write(CFG_SAMPLE_PERIOD, per);
      if (ph == 2) hold_req = 1'b1;
      n_items = $urandom_range(60, 140);
      repeat (n_items) send_beat(rand_beat(ref_pct), 1'b0, '0);
    end

    quiesce();
    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
